>>> design/bitset_mask_table_with_hex_io_top_defines.svh
// Assertion macros for the slot mask block.
// Included by the top level; depends on nothing else.
`ifndef BITSET_MASK_TABLE_WITH_HEX_IO_TOP_DEFINES_SVH
`define BITSET_MASK_TABLE_WITH_HEX_IO_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BMT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant, disabled while reset is held.
`define BMT_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

`endif

>>> design/bmt_pkg.sv
// Shared types, codes and helper functions for the slot mask block.
// No dependencies.
package bmt_pkg;

    localparam int BMT_SLOT_COUNT  = 64;
    localparam int WORD_W          = 32;
    localparam int NIB_W           = 4;
    localparam int DIGITS_PER_WORD = WORD_W / NIB_W;
    localparam int CNT_OUT_W       = 7;
    localparam int CNT_SAT         = 127;

    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_WRITE      = 3'd1,
        OP_TOGGLE     = 3'd2,
        OP_QUERY      = 3'd3,
        OP_COUNT      = 3'd4,
        OP_LOAD_BEGIN = 3'd5,
        OP_LOAD_CHAR  = 3'd6,
        OP_DUMP       = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_COUNT = 2'd1,
        KIND_DIGIT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] TEN      = 8'd10;

    // {valid, nibble} for an ASCII hex digit of either case
    function automatic logic [NIB_W:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b0;
        if (c >= CH_0 && c <= CH_9) begin
            v  = c - CH_0;
            ok = 1'b1;
        end else if (c >= CH_LA && c <= CH_LF) begin
            v  = c - CH_LA + TEN;
            ok = 1'b1;
        end else if (c >= CH_UA && c <= CH_UF) begin
            v  = c - CH_UA + TEN;
            ok = 1'b1;
        end
        return {ok, v[NIB_W-1:0]};
    endfunction

    // upper-case ASCII digit of a nibble
    function automatic logic [6:0] nib_to_ascii(input logic [NIB_W-1:0] n);
        logic [7:0] c;
        if ({4'd0, n} < TEN) begin
            c = CH_0 + {4'd0, n};
        end else begin
            c = CH_UA + {4'd0, n} - TEN;
        end
        return c[6:0];
    endfunction

    function automatic logic [2:0] pop4(input logic [NIB_W-1:0] n);
        return 3'(n[0]) + 3'(n[1]) + 3'(n[2]) + 3'(n[3]);
    endfunction

endpackage

>>> design/bitset_mask_table_with_hex_io_top.sv
// Slot mask with bit update, query, population count and hex load/dump.
// Clear all and load begin take effect as they are taken; write and toggle read the word, then
//   write it back; query and count answers are registered in S_RESULT once the output is free.
// Load char: a hex digit starts a shift walk over every word of the mask memory through its
//   single read port; dump gives one digit a cycle while the result channel is ready.
// Reset (aresetn low, synchronous): per-word valid bits, bit count and load phase clear at
//   once, so the mask reads as zero; no clearing pass over the memory.
`include "bitset_mask_table_with_hex_io_top_defines.svh"

module bitset_mask_table_with_hex_io_top
    import bmt_pkg::*;
#(
    parameter int SLOT_COUNT = BMT_SLOT_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // slot_index[15:0], bit_value[16], char_in[24:17], zero pad
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // is_set[0], total_set[7:1], hex_char[14:8], zero pad[15]
    output logic [1:0]  m_tuser,   // result_kind[1:0]
    output logic        m_tlast    // last digit of a dump; high on query and count answers
);

    // ------------------------------------------------------------------
    // Geometry derived from the slot count
    // ------------------------------------------------------------------
    localparam int NWORDS   = (SLOT_COUNT + WORD_W - 1) / WORD_W;
    localparam int WIDX_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int BITPOS_W = $clog2(WORD_W);
    localparam int TOP_BITS = SLOT_COUNT - WORD_W * (NWORDS - 1);
    localparam logic [WORD_W-1:0] TOP_MASK =
        (TOP_BITS == WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << TOP_BITS) - 64'd1);
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);
    localparam logic [2:0]        LAST_NIB  = 3'(DIGITS_PER_WORD - 1);

    // One-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RMW    = 5'b00010,
        S_RESULT = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_DUMP   = 5'b10000
    } state_t;

    // ------------------------------------------------------------------
    // Input unpacking
    // ------------------------------------------------------------------
    op_t                 in_op;
    logic [15:0]         in_idx;
    logic                in_bv;
    logic [7:0]          in_ch;
    logic                in_range;
    logic [WIDX_W-1:0]   in_word;
    logic [NIB_W:0]      in_hex;
    logic                accept;

    assign in_op    = op_t'(s_tuser);
    assign in_idx   = s_tdata[15:0];
    assign in_bv    = s_tdata[16];
    assign in_ch    = s_tdata[24:17];
    assign in_range = ({16'd0, in_idx} < 32'(SLOT_COUNT));
    assign in_word  = in_idx[BITPOS_W +: WIDX_W];
    assign in_hex   = hex_decode(in_ch);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [BITPOS_W-1:0]  bitpos_reg, bitpos_next;
    logic                 bv_reg, bv_next;
    logic                 inrange_reg, inrange_next;
    logic [WIDX_W-1:0]    word_reg, word_next;
    logic [2:0]           nibcnt_reg, nibcnt_next;
    logic [NIB_W-1:0]     carry_reg, carry_next;
    logic [NIB_W-1:0]     nib_reg, nib_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    phase_t               phase_reg, phase_next;
    logic [NWORDS-1:0]    vld_reg, vld_next;

    logic                 m_valid_reg, m_valid_next;
    kind_t                kind_reg, kind_next;
    logic                 set_reg, set_next;
    logic [CNT_OUT_W-1:0] tot_reg, tot_next;
    logic [6:0]           hex_reg, hex_next;
    logic                 last_reg, last_next;

    // Mask memory: one write and one registered read port
    logic [WORD_W-1:0]    mem [NWORDS];
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_vld_reg;
    logic                 mem_re, mem_we;
    logic [WIDX_W-1:0]    mem_raddr, mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                 out_free;
    logic [WORD_W-1:0]    word_data;   // read word, zero when never written since a clear
    logic                 old_bit, new_bit;
    logic [WORD_W-1:0]    bit_sel;
    logic [WORD_W-1:0]    shifted;
    logic [WORD_W+NIB_W-1:0] shift_ext;
    logic [NIB_W-1:0]     lost_nib;
    logic [NIB_W-1:0]     dump_nib;
    logic [CNT_OUT_W-1:0] cnt_sat;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign word_data = rd_vld_reg ? rd_data_reg : '0;
    assign bit_sel   = WORD_W'(1) << bitpos_reg;
    assign old_bit   = word_data[bitpos_reg];
    assign new_bit   = (op_reg == OP_WRITE) ? bv_reg : !old_bit;
    assign shift_ext = {word_data, carry_reg};
    assign shifted   = shift_ext[WORD_W-1:0];
    // nibble pushed past the top slot when the top word shifts
    assign lost_nib  = shift_ext[TOP_BITS +: NIB_W];
    assign dump_nib  = word_data[{nibcnt_reg, 2'b00} +: NIB_W];
    assign cnt_sat   = (32'(cnt_reg) > 32'(CNT_SAT)) ? CNT_OUT_W'(CNT_SAT)
                                                      : CNT_OUT_W'(cnt_reg);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        bitpos_next  = bitpos_reg;
        bv_next      = bv_reg;
        inrange_next = inrange_reg;
        word_next    = word_reg;
        nibcnt_next  = nibcnt_reg;
        carry_next   = carry_reg;
        nib_next     = nib_reg;
        cnt_next     = cnt_reg;
        phase_next   = phase_reg;
        vld_next     = vld_reg;

        m_valid_next = m_valid_reg && !m_tready;
        kind_next    = kind_reg;
        set_next     = set_reg;
        tot_next     = tot_reg;
        hex_next     = hex_reg;
        last_next    = last_reg;

        mem_re    = 1'b0;
        mem_raddr = in_word;
        mem_we    = 1'b0;
        mem_waddr = word_reg;
        mem_wdata = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next     = in_op;
                    bitpos_next = in_idx[BITPOS_W-1:0];
                    bv_next     = in_bv;
                    unique case (in_op)
                        OP_CLEAR: begin
                            vld_next = '0;
                            cnt_next = '0;
                        end
                        OP_WRITE, OP_TOGGLE: begin
                            // drop out-of-range updates
                            if (in_range) begin
                                mem_re     = 1'b1;
                                mem_raddr  = in_word;
                                word_next  = in_word;
                                state_next = S_RMW;
                            end
                        end
                        OP_QUERY: begin
                            inrange_next = in_range;
                            mem_re       = in_range;
                            mem_raddr    = in_word;
                            state_next   = S_RESULT;
                        end
                        OP_COUNT: begin
                            state_next = S_RESULT;
                        end
                        OP_LOAD_BEGIN: begin
                            vld_next   = '0;
                            cnt_next   = '0;
                            phase_next = PH_SKIP;
                        end
                        OP_LOAD_CHAR: begin
                            if ((phase_reg == PH_SKIP || phase_reg == PH_DIGITS) &&
                                !(phase_reg == PH_SKIP &&
                                  (in_ch == CH_SPACE || in_ch == CH_TAB))) begin
                                if (in_hex[NIB_W]) begin
                                    // start the shift walk at word 0
                                    phase_next = PH_DIGITS;
                                    nib_next   = in_hex[NIB_W-1:0];
                                    carry_next = in_hex[NIB_W-1:0];
                                    word_next  = '0;
                                    mem_re     = 1'b1;
                                    mem_raddr  = '0;
                                    state_next = S_SHIFT;
                                end else begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                        OP_DUMP: begin
                            word_next   = LAST_WORD;
                            nibcnt_next = LAST_NIB;
                            mem_re      = 1'b1;
                            mem_raddr   = LAST_WORD;
                            state_next  = S_DUMP;
                        end
                    endcase
                end
            end

            S_RMW: begin
                mem_we    = 1'b1;
                mem_waddr = word_reg;
                mem_wdata = (word_data & ~bit_sel) | (new_bit ? bit_sel : '0);
                if (new_bit && !old_bit) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end else if (old_bit && !new_bit) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                state_next = S_IDLE;
            end

            S_RESULT: begin
                // hold until the output register frees up
                if (out_free) begin
                    m_valid_next = 1'b1;
                    hex_next     = '0;
                    last_next    = 1'b1;
                    if (op_reg == OP_QUERY) begin
                        kind_next = KIND_QUERY;
                        set_next  = inrange_reg && old_bit;
                        tot_next  = '0;
                    end else begin
                        kind_next = KIND_COUNT;
                        set_next  = 1'b0;
                        tot_next  = cnt_sat;
                    end
                    state_next = S_IDLE;
                end
            end

            S_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = word_reg;
                if (word_reg == LAST_WORD) begin
                    mem_wdata  = shifted & TOP_MASK;
                    cnt_next   = cnt_reg + CNT_W'(pop4(nib_reg)) - CNT_W'(pop4(lost_nib));
                    state_next = S_IDLE;
                end else begin
                    // advance: carry the top nibble into the next word
                    mem_wdata  = shifted;
                    carry_next = word_data[WORD_W-1 -: NIB_W];
                    word_next  = word_reg + WIDX_W'(1);
                    mem_re     = 1'b1;
                    mem_raddr  = word_reg + WIDX_W'(1);
                end
            end

            S_DUMP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_DIGIT;
                    set_next     = 1'b0;
                    tot_next     = '0;
                    hex_next     = nib_to_ascii(dump_nib);
                    last_next    = (word_reg == '0) && (nibcnt_reg == '0);
                    if (nibcnt_reg == '0) begin
                        if (word_reg == '0) begin
                            state_next = S_IDLE;
                        end else begin
                            // fetch the next lower word while this word's last digit goes out
                            mem_re      = 1'b1;
                            mem_raddr   = word_reg - WIDX_W'(1);
                            word_next   = word_reg - WIDX_W'(1);
                            nibcnt_next = LAST_NIB;
                        end
                    end else begin
                        nibcnt_next = nibcnt_reg - 3'd1;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (mem_we) begin
            vld_next[mem_waddr] = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            phase_reg   <= PH_IDLE;
            vld_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            phase_reg   <= phase_next;
            vld_reg     <= vld_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        bitpos_reg  <= bitpos_next;
        bv_reg      <= bv_next;
        inrange_reg <= inrange_next;
        word_reg    <= word_next;
        nibcnt_reg  <= nibcnt_next;
        carry_reg   <= carry_next;
        nib_reg     <= nib_next;
        kind_reg    <= kind_next;
        set_reg     <= set_next;
        tot_reg     <= tot_next;
        hex_reg     <= hex_next;
        last_reg    <= last_next;
    end

    // Mask memory; the sequencer never reads and writes one word in the same cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
            rd_vld_reg  <= vld_reg[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Output packing
    // ------------------------------------------------------------------
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, hex_reg, tot_reg, set_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BMT_ASSERT_IMP(a_no_rw_same_word, aclk, aresetn, mem_re && mem_we,
        mem_raddr != mem_waddr, "read and write hit the same mask word")
    `BMT_ASSERT_IMP(a_waddr_in_range, aclk, aresetn, mem_we || mem_re,
        (32'(mem_waddr) < NWORDS) && (32'(mem_raddr) < NWORDS),
        "mask memory address beyond last word")
    `BMT_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, 32'(cnt_reg) <= SLOT_COUNT,
        "set count exceeds slot count")
    `BMT_ASSERT_IMP(a_shift_phase, aclk, aresetn, state_reg == S_SHIFT,
        phase_reg == PH_DIGITS, "shift walk outside digit phase")

endmodule
